### hdl/chme_pkg.sv
// ----------------------------------------------------------------------------
// chme_pkg
// Shared types and constants for the chained hash map engine.
// ----------------------------------------------------------------------------
package chme_pkg;

    localparam int NumBucketsDef  = 64;
    localparam int PoolEntriesDef = 256;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] value_in;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] old_value;
        logic        no_space;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_READ,
        ST_CMP,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic head_rd;
        logic ent_rd;
        logic step;
        logic commit;
        logic respond;
    } t_cmd;

    typedef struct packed {
        logic at_end;
        logic match;
        logic limit;
    } t_sts;

endpackage

### hdl/chme_ctrl.sv
// ----------------------------------------------------------------------------
// chme_ctrl
// Sequencer for the chain walk: head read, entry read, compare, commit.
// ----------------------------------------------------------------------------
module chme_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  chme_pkg::t_sts   i_sts,
    output chme_pkg::t_cmd   o_cmd,
    output logic             o_busy
);

    chme_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chme_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            chme_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = chme_pkg::ST_HEAD;
                end
            end
            chme_pkg::ST_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = chme_pkg::ST_READ;
            end
            chme_pkg::ST_READ: begin
                if (i_sts.at_end || i_sts.limit) begin
                    n_state = chme_pkg::ST_WRITE;
                end else begin
                    o_cmd.ent_rd = 1'b1;
                    n_state      = chme_pkg::ST_CMP;
                end
            end
            chme_pkg::ST_CMP: begin
                if (i_sts.match) begin
                    n_state = chme_pkg::ST_WRITE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = chme_pkg::ST_READ;
                end
            end
            chme_pkg::ST_WRITE: begin
                o_cmd.commit = 1'b1;
                n_state      = chme_pkg::ST_DONE;
            end
            chme_pkg::ST_DONE: begin
                o_cmd.respond = 1'b1;
                n_state       = chme_pkg::ST_IDLE;
            end
            default: begin
                n_state = chme_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/chme_dp.sv
// ----------------------------------------------------------------------------
// chme_dp
// Bucket heads, entry pool memories, free list and chain walk registers.
// ----------------------------------------------------------------------------
module chme_dp #(
    parameter int BUCKET_CNT   = chme_pkg::NumBucketsDef,
    parameter int POOL_ENTRIES = chme_pkg::PoolEntriesDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  chme_pkg::t_req   i_req,
    input  chme_pkg::t_cmd   i_cmd,
    output chme_pkg::t_sts   o_sts,
    output logic             o_strobe,
    output chme_pkg::t_rsp   o_rsp
);

    localparam int IW = $clog2(POOL_ENTRIES + 1);
    localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int BW = (BUCKET_CNT > 1) ? $clog2(BUCKET_CNT) : 1;
    localparam int LW = $clog2(BUCKET_CNT);
    localparam bit BktPow2 = ((BUCKET_CNT & (BUCKET_CNT - 1)) == 0);
    localparam logic [31:0] RecipM = 32'((((64'd1 << 32) *
        ((64'd1 << LW) - 64'(BUCKET_CNT))) / 64'(BUCKET_CNT)) + 64'd1);
    localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);

    logic [IW-1:0] r_heads [BUCKET_CNT];
    logic [31:0]   r_keys  [POOL_ENTRIES];
    logic [31:0]   r_vals  [POOL_ENTRIES];
    logic [IW-1:0] r_links [POOL_ENTRIES];

    logic [BUCKET_CNT-1:0] r_hvld;

    chme_pkg::t_req r_req;
    logic [BW-1:0]  r_bkt;
    logic [IW-1:0]  r_cur, r_head, r_prev, r_free, r_fresh, r_steps;
    logic [31:0]    r_ekey, r_eval;
    logic [IW-1:0]  r_elink;
    logic           r_found;
    chme_pkg::t_rsp r_rsp;

    logic [BW-1:0] w_bkt;
    logic [AW-1:0] w_cur;
    logic          w_match;
    logic [IW-1:0] w_slot;
    logic          w_hit;
    logic          w_rsp_hit;
    logic          w_nospace;

    generate
        if (BktPow2) begin : g_bkt_mask
            assign w_bkt = BW'(r_req.key & 32'(BUCKET_CNT - 1));
        end else begin : g_bkt_recip
            logic [63:0] w_prod;
            logic [31:0] r_mulhi;
            logic [31:0] w_diff;
            logic [31:0] w_quo;
            logic [31:0] w_rem;

            assign w_prod = 64'(i_req.key) * 64'(RecipM);

            always_ff @(posedge i_clk) begin
                if (i_cmd.load) begin
                    r_mulhi <= w_prod[63:32];
                end
            end

            assign w_diff = r_req.key - r_mulhi;
            assign w_quo  = (r_mulhi + (w_diff >> 1)) >> (LW - 1);
            assign w_rem  = r_req.key - (w_quo * 32'(BUCKET_CNT));
            assign w_bkt  = w_rem[BW-1:0];
        end
    endgenerate

    assign w_cur     = r_cur[AW-1:0];
    assign w_match   = (r_ekey == r_req.key);
    assign w_slot    = (r_free != NIL) ? r_free : r_fresh;
    assign w_hit     = r_found && (r_cur != NIL);
    assign w_rsp_hit = (r_req.func != chme_pkg::FUNC_NOP) && w_hit;
    assign w_nospace = (r_req.func == chme_pkg::FUNC_INSERT) && !w_hit && (w_slot == NIL);

    assign o_sts.at_end = (r_cur == NIL);
    assign o_sts.match  = w_match;
    assign o_sts.limit  = (r_steps == NIL);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req;
            r_prev  <= NIL;
            r_steps <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.head_rd) begin
            r_bkt <= w_bkt;
            if (r_hvld[w_bkt]) begin
                r_cur  <= r_heads[w_bkt];
                r_head <= r_heads[w_bkt];
            end else begin
                r_cur  <= NIL;
                r_head <= NIL;
            end
        end
        if (i_cmd.ent_rd) begin
            r_ekey  <= r_keys[w_cur];
            r_eval  <= r_vals[w_cur];
            r_elink <= r_links[w_cur];
            r_found <= 1'b1;
        end
        if (i_cmd.step) begin
            r_prev  <= r_cur;
            r_cur   <= r_elink;
            r_steps <= r_steps + 1'b1;
            r_found <= 1'b0;
        end
        if (i_cmd.commit) begin
            r_rsp.hit       <= w_rsp_hit;
            r_rsp.old_value <= w_rsp_hit ? r_eval : 32'd0;
            r_rsp.no_space  <= w_nospace;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            case (r_req.func)
                chme_pkg::FUNC_INSERT: begin
                    if (w_hit) begin
                        r_vals[w_cur] <= r_req.value_in;
                    end else if (w_slot != NIL) begin
                        r_keys[w_slot[AW-1:0]]  <= r_req.key;
                        r_vals[w_slot[AW-1:0]]  <= r_req.value_in;
                        r_links[w_slot[AW-1:0]] <= r_head;
                        r_heads[r_bkt]          <= w_slot;
                    end
                end
                chme_pkg::FUNC_REMOVE: begin
                    if (w_hit) begin
                        if (r_prev != NIL) begin
                            r_links[r_prev[AW-1:0]] <= r_elink;
                        end else begin
                            r_heads[r_bkt] <= r_elink;
                        end
                        r_links[w_cur] <= r_free;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld  <= '0;
            r_free  <= NIL;
            r_fresh <= '0;
        end else if (i_cmd.commit) begin
            case (r_req.func)
                chme_pkg::FUNC_INSERT: begin
                    if (!w_hit && w_slot != NIL) begin
                        r_hvld[r_bkt] <= 1'b1;
                        if (r_free != NIL) begin
                            r_free <= r_links[r_free[AW-1:0]];
                        end else begin
                            r_fresh <= r_fresh + 1'b1;
                        end
                    end
                end
                chme_pkg::FUNC_REMOVE: begin
                    if (w_hit) begin
                        r_free <= r_cur;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_strobe = i_cmd.respond;
    assign o_rsp    = r_rsp;

endmodule

### hdl/chained_hash_map_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Key-value map with separate chaining over a fixed entry pool.
// ----------------------------------------------------------------------------
// Usage: drive i_req (func, key, value_in) and raise start while busy is
// low; the word is taken at that edge. Insert, get and remove all walk the
// chain of bucket key mod BUCKET_CNT through the entry pool memory, each
// entry in a read state and then a compare state.
// A hit ends the walk at the compare of its entry, a miss at the end of the
// chain or at the step limit; either then commits before o_strobe rises.
// busy stays high through the strobe cycle and drops the cycle after, so a
// new request is taken only once the response of the last one is out.
// o_strobe marks o_rsp (hit, old_value, no_space) for exactly one cycle.
// The receiver cannot stall; the word must be captured on the strobe.
// Reset (synchronous, active low) empties all buckets and the free list and
// rewinds the fresh entry counter; entry memories are not cleared.
// ----------------------------------------------------------------------------
module chained_hash_map_engine #(
    parameter int BUCKET_CNT   = chme_pkg::NumBucketsDef,
    parameter int POOL_ENTRIES = chme_pkg::PoolEntriesDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  chme_pkg::t_req i_req,
    output logic           o_strobe,
    output chme_pkg::t_rsp o_rsp
);

    chme_pkg::t_cmd w_cmd;
    chme_pkg::t_sts w_sts;

    chme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    chme_dp #(
        .BUCKET_CNT   (BUCKET_CNT),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

`ifndef SYNTHESIS
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe held");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accept without busy");
    a_hit_nospace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_rsp.hit && o_rsp.no_space))
        else $error("hit with no space");
`endif

endmodule
